// ===== hdl/taylor_exp_approximation_defines.svh =====
// Assertion macros used by the top-level RTL.
`ifndef TAYLOR_EXP_APPROXIMATION_DEFINES_SVH
`define TAYLOR_EXP_APPROXIMATION_DEFINES_SVH
`ifndef SYNTH
`define TEA_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define TEA_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define TEA_ASSERT_IMPL(label, clk, rst_n, a, c)
`define TEA_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== hdl/tea_pkg.sv =====
`default_nettype none
package tea_pkg;
    localparam int unsigned WORD_W = 64;
    localparam int unsigned PROD_W = 128;
    localparam logic signed [WORD_W-1:0] SMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] SMIN = {1'b1, {(WORD_W-1){1'b0}}};
    typedef struct packed {
        logic start;
        logic busy;
    } tea_ctl_t;
endpackage
`default_nettype wire

// ===== hdl/tea_mul.sv =====
`default_nettype none
module tea_mul (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [tea_pkg::WORD_W-1:0]  a,
    input  wire logic [tea_pkg::WORD_W-1:0]  b,
    output logic                             done,
    output logic [tea_pkg::PROD_W-1:0]       prod
);
    import tea_pkg::*;
    logic [PROD_W-1:0] acc_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [6:0]        cnt_reg;
    logic              busy_reg;
    logic [PROD_W-1:0] add_w;
    assign add_w = b_reg[0] ? acc_reg + {a_reg, {WORD_W{1'b0}}} : acc_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'(WORD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            acc_reg <= {1'b0, add_w[PROD_W-1:1]};
            b_reg   <= {1'b0, b_reg[WORD_W-1:1]};
        end
    end
    assign prod = acc_reg;
endmodule
`default_nettype wire

// ===== hdl/tea_div.sv =====
`default_nettype none
module tea_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [tea_pkg::PROD_W-1:0]  num,
    input  wire logic [tea_pkg::WORD_W-1:0]  den,
    output logic                             done,
    output logic [tea_pkg::PROD_W-1:0]       quo
);
    import tea_pkg::*;
    logic [PROD_W-1:0] q_reg;
    logic [WORD_W:0]   r_reg;
    logic [WORD_W-1:0] d_reg;
    logic [7:0]        cnt_reg;
    logic              busy_reg;
    logic [WORD_W:0]   sh;
    logic [WORD_W:0]   df;
    assign sh = {r_reg[WORD_W-1:0], q_reg[PROD_W-1]};
    assign df = sh - {1'b0, d_reg};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 8'(PROD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 8'd1;
                if (cnt_reg == 8'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!df[WORD_W])
            begin
                r_reg <= df;
                q_reg <= {q_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= sh;
                q_reg <= {q_reg[PROD_W-2:0], 1'b0};
            end
        end
    end
    assign quo = q_reg;
endmodule
`default_nettype wire

// ===== hdl/tea_seq.sv =====
`default_nettype none
module tea_seq #(
    parameter int MAX_DEGREE = 255,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [22:0]                 x_in,
    input  wire logic [7:0]                         deg_in,
    input  wire logic                               recip_in,
    output logic                                    done,
    output logic signed [tea_pkg::WORD_W-1:0]       res,
    output logic                                    ovf
);
    import tea_pkg::*;
    typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_ACC, S_RDIV, S_FIN} state_t;
    localparam logic [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] RNUM = PROD_W'(1) << (2*FRAC_BITS);
    state_t            state_reg;
    logic signed [WORD_W-1:0] term_reg, sum_reg, x_reg;
    logic [7:0]        k_reg, n_reg;
    logic              neg_reg, recip_reg, ovf_reg, done_reg;
    logic              mstart, dstart, mdone, ddone;
    logic [PROD_W-1:0] prod, quo, dnum;
    logic [WORD_W-1:0] tm, xm, dden;
    logic signed [WORD_W-1:0] nt, ns;
    logic              nto, nso;
    tea_ctl_t          mctl;
    assign tm = term_reg[WORD_W-1] ? WORD_W'(-term_reg) : term_reg;
    assign xm = x_reg[WORD_W-1] ? WORD_W'(-x_reg) : x_reg;
    assign mctl.start = (state_reg == S_IDLE) && start && !(deg_in == 8'd0);
    assign mctl.busy = (state_reg == S_MUL);
    assign dnum = (state_reg == S_RDIV) ? RNUM : prod;
    assign dden = (state_reg == S_RDIV) ? ((sum_reg > 0) ? sum_reg : WORD_W'(1))
                                        : WORD_W'({k_reg}) << FRAC_BITS;
    tea_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mstart), .a(tm), .b(xm),
                   .done(mdone), .prod(prod));
    tea_div u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
                   .done(ddone), .quo(quo));
    always_comb
    begin
        nto = 1'b0;
        nt  = '0;
        if (quo[PROD_W-1:WORD_W] != '0)
        begin
            nto = 1'b1;
            nt  = neg_reg ? SMIN : SMAX;
        end
        else if (neg_reg)
        begin
            if (quo[WORD_W-1:0] > {1'b1, {(WORD_W-1){1'b0}}})
            begin
                nto = 1'b1;
                nt  = SMIN;
            end
            else
            begin
                nt = -$signed(quo[WORD_W-1:0]);
            end
        end
        else if (quo[WORD_W-1])
        begin
            nto = 1'b1;
            nt  = SMAX;
        end
        else
        begin
            nt = $signed(quo[WORD_W-1:0]);
        end
        ns  = sum_reg + term_reg;
        nso = (sum_reg[WORD_W-1] == term_reg[WORD_W-1]) && (ns[WORD_W-1] != sum_reg[WORD_W-1]);
        if (nso)
        begin
            ns = term_reg[WORD_W-1] ? SMIN : SMAX;
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            mstart    <= 1'b0;
            dstart    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            mstart   <= 1'b0;
            dstart   <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= (recip_in && x_in < 0) ? -WORD_W'(x_in) : WORD_W'(x_in);
                        n_reg     <= (deg_in > 8'(MAX_DEGREE)) ? 8'(MAX_DEGREE) : deg_in;
                        recip_reg <= recip_in;
                        term_reg  <= ONE;
                        sum_reg   <= ONE;
                        k_reg     <= 8'd1;
                        ovf_reg   <= 1'b0;
                        if (deg_in == 8'd0)
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            mstart    <= 1'b1;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    neg_reg <= term_reg[WORD_W-1] ^ x_reg[WORD_W-1];
                    if (mdone)
                    begin
                        dstart    <= 1'b1;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (ddone && !dstart)
                    begin
                        term_reg  <= nt;
                        ovf_reg   <= ovf_reg | nto;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    if (term_reg == '0)
                    begin
                        state_reg <= recip_reg ? S_RDIV : S_FIN;
                        dstart    <= recip_reg;
                    end
                    else
                    begin
                        sum_reg <= ns;
                        ovf_reg <= ovf_reg | nso;
                        if (k_reg == n_reg)
                        begin
                            state_reg <= recip_reg ? S_RDIV : S_FIN;
                            dstart    <= recip_reg;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 8'd1;
                            mstart    <= 1'b1;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_RDIV:
                begin
                    if (ddone && !dstart)
                    begin
                        sum_reg   <= $signed(quo[WORD_W-1:0]);
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
    assign done = done_reg;
    assign res  = sum_reg;
    assign ovf  = ovf_reg | (mctl.start & mctl.busy);
endmodule
`default_nettype wire

// ===== hdl/taylor_exp_approximation.sv =====
// Taylor-series exp approximation, Q6.16 in, Q47.16 out.
// Input stream s_axis: x_value, degree, reciprocal_mode in tdata.
// Output stream m_axis: approx_value and overflow_flag in tdata.
// One item is in work at a time; s_axis_tready is high only when the
// sequencer is idle. Each term runs a bit-serial multiply and a restoring
// divide, and reciprocal mode adds one more restoring divide at the end;
// a term that reaches zero ends the series early. The degree N is at most 255.
// The result waits in an output register; a stalled receiver holds it
// while the next input transaction is already taken and computed.
// A new result is presented on m_axis only after the held one was taken.
// Reset clears the state registers and the busy, pending and valid flags; the block is ready right after.
`default_nettype none
`include "taylor_exp_approximation_defines.svh"
module taylor_exp_approximation #(
    parameter int MAX_DEGREE = 255,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // x_value[22:0], degree[30:23], reciprocal_mode[31]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata   // approx_value[63:0], overflow_flag[64], zeros
);
    import tea_pkg::*;
    logic busy_reg, pend_reg, ov_reg, sdone, sovf, go, load;
    logic signed [WORD_W-1:0] sres;
    logic [WORD_W-1:0] out_reg;
    logic [WORD_W-1:0] pv_reg;
    logic pf_reg;
    assign s_axis_tready = !busy_reg;
    assign go = s_axis_tvalid && s_axis_tready;
    assign load = (!m_axis_tvalid || m_axis_tready) && (pend_reg || sdone);
    tea_seq #(.MAX_DEGREE(MAX_DEGREE), .FRAC_BITS(FRAC_BITS)) u_seq (
        .clk(clk), .rst_n(rst_n), .start(go),
        .x_in($signed(s_axis_tdata[22:0])), .deg_in(s_axis_tdata[30:23]),
        .recip_in(s_axis_tdata[31]), .done(sdone), .res(sres), .ovf(sovf));
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                busy_reg <= 1'b1;
            end
            else if (load)
            begin
                busy_reg <= 1'b0;
            end
            if (sdone && !load)
            begin
                pend_reg <= 1'b1;
                pv_reg   <= sres;
                pf_reg   <= sovf;
            end
            if (load)
            begin
                m_axis_tvalid <= 1'b1;
                out_reg       <= sdone ? sres : pv_reg;
                ov_reg        <= sdone ? sovf : pf_reg;
                pend_reg      <= 1'b0;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                m_axis_tvalid <= 1'b0;
            end
        end
    end
    assign m_axis_tdata = {7'd0, ov_reg, out_reg};
    `TEA_ASSERT_NEXT(a_busy_after_go, clk, rst_n, go, !s_axis_tready)
    `TEA_ASSERT_IMPL(a_no_accept_pending, clk, rst_n, pend_reg, !s_axis_tready)
    `TEA_ASSERT_IMPL(a_done_when_busy, clk, rst_n, sdone, busy_reg)
endmodule
`default_nettype wire

// ===== sim/taylor_exp_approximation_tb.sv =====
`default_nettype none
module taylor_exp_approximation_tb;
    import tea_pkg::*;

    localparam int        HALF_PERIOD = 6;
    localparam int        WATCHDOG    = 200000;
    localparam int        DRAIN       = 500;
    localparam int        RAND_ITEMS  = 100;
    localparam logic [63:0] ONE_Q16   = 64'd65536;

    typedef struct {
        logic signed [22:0] x_value;
        logic [7:0]         degree;
        logic               reciprocal_mode;
        logic               typed;
        logic [63:0]        approx_value;
        logic               overflow_flag;
    } exp_row_t;

    typedef struct {
        logic [63:0] approx_value;
        logic        overflow_flag;
    } exp_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // x_value[22:0], degree[30:23], reciprocal_mode[31]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // approx_value[63:0], overflow_flag[64], zeros

    exp_result_t pending_results[$];
    int          errors;
    int          idle_cycles;
    int          rx_cycle;
    exp_row_t    directed_rows[$];

    taylor_exp_approximation DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   inout logic ovf);
        logic signed [64:0] wide;
        begin
            wide = {a[63], a} + {b[63], b};
            if (wide > $signed({1'b0, SMAX}))
            begin
                ovf = 1'b1;
                return SMAX;
            end
            if (wide < $signed({1'b1, SMIN}))
            begin
                ovf = 1'b1;
                return SMIN;
            end
            return wide[63:0];
        end
    endfunction

    function automatic logic signed [63:0] step_term(input logic signed [63:0] term,
                                                     input logic signed [63:0] x,
                                                     input int unsigned k,
                                                     inout logic ovf);
        logic         neg;
        logic [63:0]  tm;
        logic [63:0]  xm;
        logic [127:0] quot;
        begin
            neg  = term[63] != x[63];
            tm   = term[63] ? -term : term;
            xm   = x[63] ? -x : x;
            quot = ({64'd0, tm} * {64'd0, xm}) / (128'(k) << 16);
            if (quot[127:64] != 0)
            begin
                ovf = 1'b1;
                return neg ? SMIN : SMAX;
            end
            if (neg)
            begin
                if (quot[63:0] > 64'h8000_0000_0000_0000)
                begin
                    ovf = 1'b1;
                    return SMIN;
                end
                return -quot[63:0];
            end
            if (quot[63])
            begin
                ovf = 1'b1;
                return SMAX;
            end
            return quot[63:0];
        end
    endfunction

    function automatic exp_result_t predict_exp(input logic signed [22:0] xv,
                                                input logic [7:0] degree,
                                                input logic reciprocal_mode);
        exp_result_t      r;
        logic signed [63:0] x;
        logic signed [63:0] term;
        logic signed [63:0] sum;
        logic [63:0]      den;
        logic             ovf;
        begin
            ovf  = 1'b0;
            x    = 64'(xv);
            if (reciprocal_mode && x < 0)
                x = -x;
            term = ONE_Q16;
            sum  = ONE_Q16;
            for (int k = 1; k <= degree; k++)
            begin
                term = step_term(term, x, k, ovf);
                if (term == 0)
                    break;
                sum = sat_sum(sum, term, ovf);
            end
            if (reciprocal_mode)
            begin
                den = (sum > 0) ? sum : 64'd1;
                r.approx_value = (64'd1 << 32) / den;
            end
            else
                r.approx_value = sum;
            r.overflow_flag = ovf;
            return r;
        end
    endfunction

    task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
        begin
            $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
            errors++;
        end
    endtask

    task automatic send_item(input exp_row_t row, input logic allow_gap);
        exp_result_t want;
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {row.reciprocal_mode, row.degree, row.x_value};
            do
                @(posedge clk);
            while (!s_axis_tready);
            if (row.typed)
            begin
                want.approx_value  = row.approx_value;
                want.overflow_flag = row.overflow_flag;
            end
            else
                want = predict_exp(row.x_value, row.degree, row.reciprocal_mode);
            pending_results.push_back(want);
            if (allow_gap && $urandom_range(99) < 10)
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= $urandom;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    function automatic exp_row_t make_row(input logic signed [22:0] x, input logic [7:0] degree,
                                          input logic rm, input logic typed,
                                          input logic [63:0] value, input logic ovf);
        exp_row_t row;
        begin
            row.x_value         = x;
            row.degree          = degree;
            row.reciprocal_mode = rm;
            row.typed           = typed;
            row.approx_value    = value;
            row.overflow_flag   = ovf;
            return row;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle < 2000)
                m_axis_tready <= 1'b0;
            else if (rx_cycle >= 20000 && rx_cycle < 60000)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 10);
        end
    end

    always @(posedge clk)
    begin
        exp_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report("unexpected result", m_axis_tdata[63:0], 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[63:0] !== want.approx_value)
                    report("approx_value", m_axis_tdata[63:0], want.approx_value);
                if (m_axis_tdata[64] !== want.overflow_flag)
                    report("overflow_flag", 64'(m_axis_tdata[64]), 64'(want.overflow_flag));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("taylor_exp_approximation_tb failed");
            $finish;
        end
    end

    initial
    begin
        exp_row_t         row;
        logic signed [22:0] x;
        logic [7:0]       degree;
        int               pick;
        errors        = 0;
        idle_cycles   = 0;
        rx_cycle      = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        directed_rows.push_back(make_row(23'sd0, 8'd0, 1'b0, 1'b1, ONE_Q16, 1'b0));
        directed_rows.push_back(make_row(23'sh3FFFFF, 8'd0, 1'b0, 1'b1, ONE_Q16, 1'b0));
        directed_rows.push_back(make_row(-23'sd2097152, 8'd0, 1'b1, 1'b1, ONE_Q16, 1'b0));
        directed_rows.push_back(make_row(23'sd0, 8'd1, 1'b0, 1'b1, ONE_Q16, 1'b0));
        directed_rows.push_back(make_row(23'sd65536, 8'd1, 1'b0, 1'b1, 64'd131072, 1'b0));
        directed_rows.push_back(make_row(-23'sd2097152, 8'd1, 1'b0, 1'b1,
                                         64'(65536 - 2097152), 1'b0));
        directed_rows.push_back(make_row(23'sd2097152, 8'd1, 1'b0, 1'b1,
                                         64'd2162688, 1'b0));
        directed_rows.push_back(make_row(23'sd2097152, 8'd255, 1'b0, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(23'sh3FFFFF, 8'd255, 1'b0, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(-23'sh400000, 8'd255, 1'b0, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(-23'sh400000, 8'd255, 1'b1, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(23'sd2097152, 8'd40, 1'b1, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(-23'sd65536, 8'd10, 1'b0, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(23'sd1, 8'hAA, 1'b0, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(23'sh155555, 8'h55, 1'b1, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(-23'sd1, 8'd3, 1'b0, 1'b0, '0, 1'b0));
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            send_item(directed_rows[i], 1'b1);
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                x = 23'($signed($urandom_range(0, 4194304)) - 2097152);
            else if (pick < 75)
                x = 23'($signed($urandom_range(0, 262144)) - 131072);
            else
                x = 23'($urandom);
            pick = $urandom_range(99);
            if (pick < 3)
                degree = 8'd255;
            else if (pick < 13)
                degree = 8'($urandom_range(25, 80));
            else
                degree = 8'($urandom_range(0, 24));
            row = make_row(x, degree, 1'($urandom), 1'b0, '0, 1'b0);
            send_item(row, !(i >= 40 && i < 70));
        end
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("taylor_exp_approximation_tb passed");
        else
            $display("taylor_exp_approximation_tb failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/tea_pkg.sv
hdl/tea_mul.sv
hdl/tea_div.sv
hdl/tea_seq.sv
hdl/taylor_exp_approximation.sv
sim/taylor_exp_approximation_tb.sv
